// ----- rtl/sdalu_pkg.sv -----
// Package for the saturating DSP ALU: operation codes, word types and
// saturation helper functions. No dependencies.
`default_nettype none

package sdalu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned RegW  = 4;
  localparam logic [RegW-1:0] PcIndex = 4'd15;

  typedef enum logic [3:0] {
    OP_SSAT   = 4'd0,
    OP_SSAT16 = 4'd1,
    OP_USAT   = 4'd2,
    OP_USAT16 = 4'd3,
    OP_QADD   = 4'd4,
    OP_QSUB   = 4'd5,
    OP_QDADD  = 4'd6,
    OP_QDSUB  = 4'd7,
    OP_QASX   = 4'd8,
    OP_QSAX   = 4'd9,
    OP_UQASX  = 4'd10,
    OP_UQSAX  = 4'd11
  } op_e;

  // One input word as held in the input register
  typedef struct packed {
    logic [3:0]       operation;
    logic [WordW-1:0] rn_value;
    logic [WordW-1:0] rm_value;
    logic [RegW-1:0]  rn_index;
    logic [RegW-1:0]  rm_index;
    logic [RegW-1:0]  dest_reg;
    logic [4:0]       sat_imm;
    logic [4:0]       shift_amount;
    logic             shift_is_asr;
    logic             cond_passed;
  } item_t;

  // One result word as held in the output register
  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic             write_enable;
    logic [RegW-1:0]  write_reg;
    logic             sticky_q;
    logic             unpredictable;
  } result_t;

  // Signed saturation of a word to k+1 bits; returns {overflow, value}
  function automatic logic [WordW:0] sat_signed32(logic [WordW-1:0] v, logic [4:0] k);
    logic [WordW-1:0] sh;
    logic [WordW-1:0] hi;
    logic             fits;
    sh   = $signed(v) >>> k;
    fits = (sh == '0) || (sh == '1);
    hi   = (WordW'(1) << k) - WordW'(1);
    if (fits) return {1'b0, v};
    return {1'b1, (v[WordW-1] ? ~hi : hi)};
  endfunction

  // Unsigned saturation of a signed word to k bits; returns {overflow, value}
  function automatic logic [WordW:0] sat_unsigned32(logic [WordW-1:0] v, logic [4:0] k);
    logic [WordW-1:0] hi;
    hi = (WordW'(1) << k) - WordW'(1);
    if (v[WordW-1]) return {1'b1, {WordW{1'b0}}};
    if ((v >> k) != '0) return {1'b1, hi};
    return {1'b0, v};
  endfunction

  // Signed saturation of a half to k+1 bits; returns {overflow, value}
  function automatic logic [HalfW:0] sat_signed16(logic [HalfW-1:0] v, logic [3:0] k);
    logic [HalfW-1:0] sh;
    logic [HalfW-1:0] hi;
    logic             fits;
    sh   = $signed(v) >>> k;
    fits = (sh == '0) || (sh == '1);
    hi   = (HalfW'(1) << k) - HalfW'(1);
    if (fits) return {1'b0, v};
    return {1'b1, (v[HalfW-1] ? ~hi : hi)};
  endfunction

  // Unsigned saturation of a signed half to k bits; returns {overflow, value}
  function automatic logic [HalfW:0] sat_unsigned16(logic [HalfW-1:0] v, logic [3:0] k);
    logic [HalfW-1:0] hi;
    hi = (HalfW'(1) << k) - HalfW'(1);
    if (v[HalfW-1]) return {1'b1, {HalfW{1'b0}}};
    if ((v >> k) != '0) return {1'b1, hi};
    return {1'b0, v};
  endfunction

  // 17-bit signed sum/difference of two halves, clamped to signed 16 bits
  function automatic logic [HalfW-1:0] clamp_s16(logic [HalfW:0] s);
    if (s[HalfW] != s[HalfW-1]) return s[HalfW] ? 16'h8000 : 16'h7FFF;
    return s[HalfW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sdalu_if.sv -----
// Valid/ready channel interfaces for the saturating DSP ALU.
// No dependencies; the field widths are written out as literals.
`default_nettype none

interface sdalu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] rn_value;
  logic [31:0] rm_value;
  logic [3:0]  rn_index;
  logic [3:0]  rm_index;
  logic [3:0]  dest_reg;
  logic [4:0]  sat_imm;
  logic [4:0]  shift_amount;
  logic        shift_is_asr;
  logic        cond_passed;

  modport source (
    output valid, operation, rn_value, rm_value, rn_index, rm_index, dest_reg,
           sat_imm, shift_amount, shift_is_asr, cond_passed,
    input  ready
  );
  modport sink (
    input  valid, operation, rn_value, rm_value, rn_index, rm_index, dest_reg,
           sat_imm, shift_amount, shift_is_asr, cond_passed,
    output ready
  );
endinterface

interface sdalu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        write_enable;
  logic [3:0]  write_reg;
  logic        sticky_q;
  logic        unpredictable;

  modport source (
    output valid, result_value, write_enable, write_reg, sticky_q, unpredictable,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_enable, write_reg, sticky_q, unpredictable,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/sdalu_exec.sv -----
// Combinational execute logic: shift, saturate, saturating add/sub and the
// exchange forms. Depends on sdalu_pkg.
`default_nettype none

module sdalu_exec (
  input  var sdalu_pkg::item_t   item_i,
  input  var logic               q_i,
  output var sdalu_pkg::result_t res_o,
  output var logic               set_q_o
);

  sdalu_pkg::op_e op;
  logic           unpred;
  logic           we;
  logic [31:0]    shifted;
  logic [31:0]    rn;
  logic [31:0]    rm;
  logic [32:0]    sat_w;
  logic [16:0]    sat_lo;
  logic [16:0]    sat_hi;
  logic [32:0]    sum;
  logic [32:0]    dbl;
  logic [31:0]    dbl_sat;
  logic           dbl_ovf;
  logic [16:0]    hs_lo;
  logic [16:0]    hs_hi;
  logic [31:0]    value;
  logic           ovf;

  assign op = sdalu_pkg::op_e'(item_i.operation);
  assign rn = item_i.rn_value;
  assign rm = item_i.rm_value;

  // PC operand check; unused codes do nothing at all
  always_comb begin
    unpred = 1'b0;
    if (item_i.operation inside {[sdalu_pkg::OP_SSAT:sdalu_pkg::OP_UQSAX]}) begin
      unpred = (item_i.dest_reg == sdalu_pkg::PcIndex) ||
               (item_i.rn_index == sdalu_pkg::PcIndex) ||
               ((item_i.operation inside {[sdalu_pkg::OP_QADD:sdalu_pkg::OP_UQSAX]}) &&
                (item_i.rm_index == sdalu_pkg::PcIndex));
    end
  end
  assign we = !unpred && item_i.cond_passed &&
              (item_i.operation inside {[sdalu_pkg::OP_SSAT:sdalu_pkg::OP_UQSAX]});

  // Immediate shift for SSAT/USAT; ASR #0 means ASR #32
  always_comb begin
    if (!item_i.shift_is_asr) begin
      shifted = rn << item_i.shift_amount;
    end else if (item_i.shift_amount == '0) begin
      shifted = {32{rn[31]}};
    end else begin
      shifted = $signed(rn) >>> item_i.shift_amount;
    end
  end

  // Doubling of Rn for QDADD/QDSUB
  assign dbl     = {rn[31], rn} + {rn[31], rn};
  assign dbl_ovf = (dbl[32] != dbl[31]);
  assign dbl_sat = dbl_ovf ? (dbl[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dbl[31:0];

  // Operation select
  always_comb begin
    value  = '0;
    ovf    = 1'b0;
    sat_w  = '0;
    sat_lo = '0;
    sat_hi = '0;
    sum    = '0;
    hs_lo  = '0;
    hs_hi  = '0;
    case (op)
      sdalu_pkg::OP_SSAT: begin
        sat_w = sdalu_pkg::sat_signed32(shifted, item_i.sat_imm);
        value = sat_w[31:0];
        ovf   = sat_w[32];
      end
      sdalu_pkg::OP_USAT: begin
        sat_w = sdalu_pkg::sat_unsigned32(shifted, item_i.sat_imm);
        value = sat_w[31:0];
        ovf   = sat_w[32];
      end
      sdalu_pkg::OP_SSAT16: begin
        sat_lo = sdalu_pkg::sat_signed16(rn[15:0], item_i.sat_imm[3:0]);
        sat_hi = sdalu_pkg::sat_signed16(rn[31:16], item_i.sat_imm[3:0]);
        value  = {sat_hi[15:0], sat_lo[15:0]};
        ovf    = sat_lo[16] | sat_hi[16];
      end
      sdalu_pkg::OP_USAT16: begin
        sat_lo = sdalu_pkg::sat_unsigned16(rn[15:0], item_i.sat_imm[3:0]);
        sat_hi = sdalu_pkg::sat_unsigned16(rn[31:16], item_i.sat_imm[3:0]);
        value  = {sat_hi[15:0], sat_lo[15:0]};
        ovf    = sat_lo[16] | sat_hi[16];
      end
      sdalu_pkg::OP_QADD, sdalu_pkg::OP_QSUB, sdalu_pkg::OP_QDADD,
      sdalu_pkg::OP_QDSUB: begin
        if (op == sdalu_pkg::OP_QADD) begin
          sum = {rm[31], rm} + {rn[31], rn};
        end else if (op == sdalu_pkg::OP_QSUB) begin
          sum = {rm[31], rm} - {rn[31], rn};
        end else if (op == sdalu_pkg::OP_QDADD) begin
          sum = {rm[31], rm} + {dbl_sat[31], dbl_sat};
        end else begin
          sum = {rm[31], rm} - {dbl_sat[31], dbl_sat};
        end
        ovf   = (sum[32] != sum[31]) ||
                (dbl_ovf && (op == sdalu_pkg::OP_QDADD || op == sdalu_pkg::OP_QDSUB));
        value = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : sum[31:0];
      end
      sdalu_pkg::OP_QASX: begin
        hs_lo = {rn[15], rn[15:0]} - {rm[31], rm[31:16]};
        hs_hi = {rn[31], rn[31:16]} + {rm[15], rm[15:0]};
        value = {sdalu_pkg::clamp_s16(hs_hi), sdalu_pkg::clamp_s16(hs_lo)};
      end
      sdalu_pkg::OP_QSAX: begin
        hs_lo = {rn[15], rn[15:0]} + {rm[31], rm[31:16]};
        hs_hi = {rn[31], rn[31:16]} - {rm[15], rm[15:0]};
        value = {sdalu_pkg::clamp_s16(hs_hi), sdalu_pkg::clamp_s16(hs_lo)};
      end
      sdalu_pkg::OP_UQASX: begin
        // low half: borrow clamps to 0; high half: carry clamps to all ones
        hs_lo = {1'b0, rn[15:0]} - {1'b0, rm[31:16]};
        hs_hi = {1'b0, rn[31:16]} + {1'b0, rm[15:0]};
        value = {(hs_hi[16] ? 16'hFFFF : hs_hi[15:0]), (hs_lo[16] ? 16'h0000 : hs_lo[15:0])};
      end
      sdalu_pkg::OP_UQSAX: begin
        hs_lo = {1'b0, rn[15:0]} + {1'b0, rm[31:16]};
        hs_hi = {1'b0, rn[31:16]} - {1'b0, rm[15:0]};
        value = {(hs_hi[16] ? 16'h0000 : hs_hi[15:0]), (hs_lo[16] ? 16'hFFFF : hs_lo[15:0])};
      end
      default: begin
        value = '0;
        ovf   = 1'b0;
      end
    endcase
  end

  assign set_q_o = we && ovf;

  always_comb begin
    res_o.result_value  = we ? value : '0;
    res_o.write_enable  = we;
    res_o.write_reg     = item_i.dest_reg;
    res_o.sticky_q      = q_i | set_q_o;
    res_o.unpredictable = unpred;
  end

endmodule

`default_nettype wire

// ----- rtl/saturating_dsp_alu.sv -----
// Top level of the saturating DSP ALU: input register, execute logic and
// result register with the sticky Q flag. Depends on sdalu_pkg, sdalu_if, sdalu_exec.
//
//   channel | dir | word                                   | handshake
//   in_i    | in  | operation, operands, indices, immediates | valid/ready
//   out_o   | out | result, write enable/reg, Q, unpredictable | valid/ready
//
// One word per cycle sustained while out_o is not stalled; a word passes the input
// register, then the result register after the execute logic, before it shows at out_o.
// Reset clears both valid bits and the Q flag.
// When out_o stalls, the input register still fills; in_i.ready drops only
// when both registers hold words and the result is not being taken.
`default_nettype none

module saturating_dsp_alu (
  input  wire           clk_i,
  input  wire           rst_ni,
  sdalu_in_if.sink      in_i,
  sdalu_out_if.source   out_o
);

  sdalu_pkg::item_t   s1_q;
  sdalu_pkg::item_t   s1_d;
  logic               v1_q;
  sdalu_pkg::result_t s2_q;
  sdalu_pkg::result_t s2_d;
  logic               v2_q;
  logic               q_q;
  logic               set_q;
  logic               adv2;
  logic               adv1;

  // Stage advance
  assign adv2       = !v2_q || out_o.ready;
  assign adv1       = !v1_q || adv2;
  assign in_i.ready = adv1;

  always_comb begin
    s1_d.operation    = in_i.operation;
    s1_d.rn_value     = in_i.rn_value;
    s1_d.rm_value     = in_i.rm_value;
    s1_d.rn_index     = in_i.rn_index;
    s1_d.rm_index     = in_i.rm_index;
    s1_d.dest_reg     = in_i.dest_reg;
    s1_d.sat_imm      = in_i.sat_imm;
    s1_d.shift_amount = in_i.shift_amount;
    s1_d.shift_is_asr = in_i.shift_is_asr;
    s1_d.cond_passed  = in_i.cond_passed;
  end

  sdalu_exec u_exec (
    .item_i  (s1_q),
    .q_i     (q_q),
    .res_o   (s2_d),
    .set_q_o (set_q)
  );

  // Control: valid bits and sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      q_q  <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv2 && v1_q && set_q) q_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
  end

  assign out_o.valid         = v2_q;
  assign out_o.result_value  = s2_q.result_value;
  assign out_o.write_enable  = s2_q.write_enable;
  assign out_o.write_reg     = s2_q.write_reg;
  assign out_o.sticky_q      = s2_q.sticky_q;
  assign out_o.unpredictable = s2_q.unpredictable;

endmodule

`default_nettype wire

// ----- rtl/sdalu_checker.sv -----
// Port-level assertions for saturating_dsp_alu and the bind that attaches them.
// Depends on the top level's ports and on sdalu_pkg for the PC index.
`default_nettype none

module sdalu_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] result_value_i,
  input wire        write_enable_i,
  input wire [3:0]  write_reg_i,
  input wire        sticky_q_i,
  input wire        unpredictable_i
);

  // Q is sticky: a valid result that shows it is not followed directly by a valid result without it
  a_q_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sticky_q_i |=> !out_valid_i || sticky_q_i)
    else $error("sticky Q cleared");

  // PC operand never writes
  a_unpred_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unpredictable_i |-> !write_enable_i)
    else $error("write despite PC operand");

  // A write never targets PC and never comes with the unpredictable flag
  a_no_pc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && write_enable_i |-> write_reg_i != sdalu_pkg::PcIndex && !unpredictable_i)
    else $error("write to PC");

  // No write means a zero result
  a_zero_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !write_enable_i |-> result_value_i == 32'd0)
    else $error("nonzero result without write");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_value_i) &&
                                    $stable(sticky_q_i))
    else $error("stalled result changed");

endmodule

bind saturating_dsp_alu sdalu_checker u_sdalu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .result_value_i  (out_o.result_value),
  .write_enable_i  (out_o.write_enable),
  .write_reg_i     (out_o.write_reg),
  .sticky_q_i      (out_o.sticky_q),
  .unpredictable_i (out_o.unpredictable)
);

`default_nettype wire
